// ===== sv/ppc_pkg.sv =====
// Shared constants and codes for the proximity pulse calibration block.
`timescale 1ns / 1ps

package ppc_pkg;

    // Store geometry
    localparam int STORE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

    // Field widths
    localparam int LEVEL_W = 15;
    localparam int SAMPLE_W = 16;
    localparam int PULSE_W = 8;
    localparam int STEP_W  = 9;

    // Divide by three: x * ceil(2^17 / 3) >> 17 is exact for 16-bit x
    localparam int DIV3_SHIFT = 17;
    localparam logic [DIV3_SHIFT-1:0] DIV3_RECIP = DIV3_SHIFT'(43691);
    localparam int PROD_W = SAMPLE_W + DIV3_SHIFT;

    // Action codes
    localparam logic [1:0] ACT_BEGIN_AHEAD   = 2'd0;
    localparam logic [1:0] ACT_BEGIN_DISPLAY = 2'd1;
    localparam logic [1:0] ACT_READING       = 2'd2;
    localparam logic [1:0] ACT_MISSED        = 2'd3;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PULSE  = 1'd1;
    localparam int CFG_DATA_W = 16;

    // Register reset values
    localparam logic [SAMPLE_W-1:0] FULL_SCALE_RESET = 16'd1023;
    localparam logic [PULSE_W-1:0]  MAX_PULSE_RESET  = 8'hFF;

endpackage

// ===== sv/proximity_pulse_calibration.sv =====
// Top level: proximity LED pulse-count sweep, averaging and best-count search.
`timescale 1ns / 1ps

// One beat in gives exactly one beat out. Begin beats, readings that arrive
// outside a sweep and the first two readings of each slot group go from
// acceptance through the output state to the result register; the reading
// that completes a group of three goes through the multiply, average and
// output states (the sum goes through one reciprocal multiplier for the
// divide by three, then the average is stored and the end tests run). When a
// sweep ends and both sides hold data, the best-count search walks the common
// store entries through one read port per store and one shared subtract and
// compare unit, one entry at a time over the n common entries (n at most
// 64). The input is not ready while a beat is in work; the result register
// holds a finished beat until it is taken, and the next beat may be accepted
// meanwhile. A finished beat that finds the result register still occupied
// waits inside the block, with the input not ready, until the register is
// taken. Configuration writes are taken at any time and should only be
// issued while the block is idle.
module proximity_pulse_calibration (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration
    input  logic                             cfg_wr_en,
    input  logic [ppc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ppc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // input beats
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [1:0]                       s_action,
    input  logic [ppc_pkg::SAMPLE_W-1:0]     s_reading,
    // result beats
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [ppc_pkg::PULSE_W-1:0]      m_pulse_count,
    output logic                             m_ignored,
    output logic                             m_average_valid,
    output logic [ppc_pkg::LEVEL_W-1:0]      m_average_level,
    output logic                             m_sweep_done,
    output logic                             m_done_side,
    output logic                             m_calibrated,
    output logic [ppc_pkg::PULSE_W-1:0]      m_best_pulse_count,
    output logic [ppc_pkg::LEVEL_W-1:0]      m_ahead_level_out,
    output logic [ppc_pkg::LEVEL_W-1:0]      m_display_level_out
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_AVG,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_FIN,
        ST_OUT
    } state_t;

    state_t state_reg;

    // configuration
    logic [ppc_pkg::SAMPLE_W-1:0] full_scale_reg;
    logic [ppc_pkg::PULSE_W-1:0]  max_pulse_reg;

    // sweep state
    logic                         active_reg;
    logic                         is_ahead_reg;
    logic [1:0]                   slot_reg;
    logic [ppc_pkg::SAMPLE_W-1:0] sum_reg;
    logic [ppc_pkg::CNT_W-1:0]    fill_reg;
    logic [ppc_pkg::STEP_W-1:0]   pcnt_reg;
    logic [ppc_pkg::CNT_W-1:0]    ahead_cnt_reg;
    logic [ppc_pkg::CNT_W-1:0]    display_cnt_reg;
    logic [ppc_pkg::PROD_W-1:0]   prod_reg;

    // chosen result
    logic                         calib_reg;
    logic [ppc_pkg::PULSE_W-1:0]  chosen_cnt_reg;
    logic [ppc_pkg::LEVEL_W-1:0]  chosen_ahead_reg;
    logic [ppc_pkg::LEVEL_W-1:0]  chosen_display_reg;

    // search state
    logic [ppc_pkg::CNT_W-1:0]    scan_i_reg;
    logic [ppc_pkg::CNT_W-1:0]    scan_n_reg;
    logic [ppc_pkg::CNT_W-1:0]    pick_reg;
    logic [ppc_pkg::LEVEL_W-1:0]  best_reg;
    logic [ppc_pkg::LEVEL_W-1:0]  ahead_q_reg;
    logic [ppc_pkg::LEVEL_W-1:0]  display_q_reg;

    // pending result fields
    logic [ppc_pkg::PULSE_W-1:0]  res_pc_reg;
    logic                         res_ignored_reg;
    logic                         res_avg_valid_reg;
    logic [ppc_pkg::LEVEL_W-1:0]  res_avg_reg;
    logic                         res_done_reg;
    logic                         res_side_reg;

    // result register
    logic                         m_valid_reg;
    logic [ppc_pkg::PULSE_W-1:0]  m_pc_reg;
    logic                         m_ignored_reg;
    logic                         m_avg_valid_reg;
    logic [ppc_pkg::LEVEL_W-1:0]  m_avg_reg;
    logic                         m_done_reg;
    logic                         m_side_reg;
    logic                         m_calib_reg;
    logic [ppc_pkg::PULSE_W-1:0]  m_best_reg;
    logic [ppc_pkg::LEVEL_W-1:0]  m_ahead_reg;
    logic [ppc_pkg::LEVEL_W-1:0]  m_display_reg;

    // level stores
    logic [ppc_pkg::LEVEL_W-1:0]  ahead_mem   [ppc_pkg::STORE_DEPTH];
    logic [ppc_pkg::LEVEL_W-1:0]  display_mem [ppc_pkg::STORE_DEPTH];

    // combinational helpers
    logic                         accept;
    logic                         is_begin;
    logic [ppc_pkg::SAMPLE_W-1:0] sum_next;
    logic [ppc_pkg::LEVEL_W-1:0]  avg;
    logic [ppc_pkg::CNT_W-1:0]    fill_next;
    logic [ppc_pkg::STEP_W-1:0]   pcnt_next;
    logic [ppc_pkg::CNT_W-1:0]    ahead_cnt_next;
    logic [ppc_pkg::CNT_W-1:0]    display_cnt_next;
    logic                         sweep_end;
    logic [ppc_pkg::LEVEL_W-1:0]  diff;
    logic [ppc_pkg::ADDR_W-1:0]   wr_addr;
    logic [ppc_pkg::ADDR_W-1:0]   rd_addr;
    logic                         store_we;
    logic                         out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign is_begin = (s_action == ppc_pkg::ACT_BEGIN_AHEAD)
                   || (s_action == ppc_pkg::ACT_BEGIN_DISPLAY);

    // slot accumulation, 16-bit wrap; a missed slot adds nothing
    assign sum_next = sum_reg + ((s_action == ppc_pkg::ACT_READING) ? s_reading
                                                                     : '0);

    // average and sweep end tests
    assign avg       = prod_reg[ppc_pkg::DIV3_SHIFT +: ppc_pkg::LEVEL_W];
    assign fill_next = fill_reg + 1'b1;
    assign pcnt_next = pcnt_reg + 1'b1;
    assign sweep_end = ({1'b0, avg} >= full_scale_reg)
                    || (pcnt_next > {1'b0, max_pulse_reg})
                    || (fill_next >= ppc_pkg::CNT_W'(ppc_pkg::STORE_DEPTH));
    assign ahead_cnt_next   = is_ahead_reg ? fill_next : ahead_cnt_reg;
    assign display_cnt_next = is_ahead_reg ? display_cnt_reg : fill_next;

    // shared absolute difference unit for the search
    assign diff = (ahead_q_reg > display_q_reg) ? (ahead_q_reg - display_q_reg)
                                                : (display_q_reg - ahead_q_reg);

    assign wr_addr  = fill_reg[ppc_pkg::ADDR_W-1:0];
    assign rd_addr  = scan_i_reg[ppc_pkg::ADDR_W-1:0];
    assign store_we = (state_reg == ST_AVG);

    // ahead store: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (store_we && is_ahead_reg) begin
            ahead_mem[wr_addr] <= avg;
        end
        if (state_reg == ST_SCAN_RD) begin
            ahead_q_reg <= ahead_mem[rd_addr];
        end
    end

    // display store
    always_ff @(posedge aclk) begin
        if (store_we && !is_ahead_reg) begin
            display_mem[wr_addr] <= avg;
        end
        if (state_reg == ST_SCAN_RD) begin
            display_q_reg <= display_mem[rd_addr];
        end
    end

    // sequencer, sweep state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_IDLE;
            full_scale_reg     <= ppc_pkg::FULL_SCALE_RESET;
            max_pulse_reg      <= ppc_pkg::MAX_PULSE_RESET;
            active_reg         <= 1'b0;
            is_ahead_reg       <= 1'b0;
            slot_reg           <= '0;
            sum_reg            <= '0;
            fill_reg           <= '0;
            pcnt_reg           <= ppc_pkg::STEP_W'(1);
            ahead_cnt_reg      <= '0;
            display_cnt_reg    <= '0;
            calib_reg          <= 1'b0;
            chosen_cnt_reg     <= '0;
            chosen_ahead_reg   <= '0;
            chosen_display_reg <= '0;
            m_valid_reg        <= 1'b0;
        end else begin
            // configuration writes
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    ppc_pkg::REG_FULL_SCALE: full_scale_reg <= cfg_wdata;
                    ppc_pkg::REG_MAX_PULSE:
                        max_pulse_reg <= cfg_wdata[ppc_pkg::PULSE_W-1:0];
                endcase
            end

            // result taken downstream; a reload in ST_OUT takes its place
            if (m_valid_reg && m_ready && state_reg != ST_OUT) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        res_ignored_reg   <= !is_begin && !active_reg;
                        res_avg_valid_reg <= 1'b0;
                        res_avg_reg       <= '0;
                        res_done_reg      <= 1'b0;
                        res_side_reg      <= 1'b0;
                        state_reg         <= (!is_begin && active_reg && slot_reg == 2'd2)
                                             ? ST_MUL : ST_OUT;
                        if (is_begin) begin
                            active_reg   <= 1'b1;
                            is_ahead_reg <= (s_action == ppc_pkg::ACT_BEGIN_AHEAD);
                            slot_reg     <= '0;
                            sum_reg      <= '0;
                            fill_reg     <= '0;
                            pcnt_reg     <= ppc_pkg::STEP_W'(1);
                            res_pc_reg   <= ppc_pkg::PULSE_W'(1);
                        end else if (!active_reg) begin
                            res_pc_reg      <= calib_reg ? chosen_cnt_reg
                                                         : ppc_pkg::PULSE_W'(1);
                        end else begin
                            sum_reg <= sum_next;
                            if (slot_reg != 2'd2) begin
                                slot_reg   <= slot_reg + 1'b1;
                                res_pc_reg <= pcnt_reg[ppc_pkg::PULSE_W-1:0];
                            end
                        end
                    end
                end

                // divide by three through the reciprocal
                ST_MUL: begin
                    prod_reg  <= sum_reg * ppc_pkg::DIV3_RECIP;
                    state_reg <= ST_AVG;
                end

                // store the average, step the count, test for sweep end
                ST_AVG: begin
                    res_avg_valid_reg <= 1'b1;
                    res_avg_reg       <= avg;
                    slot_reg          <= '0;
                    sum_reg           <= '0;
                    fill_reg          <= fill_next;
                    pcnt_reg          <= pcnt_next;
                    if (sweep_end) begin
                        res_done_reg    <= 1'b1;
                        res_side_reg    <= is_ahead_reg;
                        active_reg      <= 1'b0;
                        ahead_cnt_reg   <= ahead_cnt_next;
                        display_cnt_reg <= display_cnt_next;
                        if (ahead_cnt_next != '0 && display_cnt_next != '0) begin
                            scan_n_reg <= (ahead_cnt_next < display_cnt_next)
                                          ? ahead_cnt_next : display_cnt_next;
                            scan_i_reg <= '0;
                            pick_reg   <= ppc_pkg::CNT_W'(1);
                            best_reg   <= '0;
                            state_reg  <= ST_SCAN_RD;
                        end else begin
                            res_pc_reg <= ppc_pkg::PULSE_W'(1);
                            state_reg  <= ST_OUT;
                        end
                    end else begin
                        res_pc_reg <= pcnt_next[ppc_pkg::PULSE_W-1:0];
                        state_reg  <= ST_OUT;
                    end
                end

                // read both stores at the scan index
                ST_SCAN_RD: begin
                    state_reg <= (scan_i_reg == scan_n_reg) ? ST_FIN : ST_SCAN_CMP;
                end

                // keep the first largest difference
                ST_SCAN_CMP: begin
                    if (diff > best_reg) begin
                        best_reg           <= diff;
                        chosen_ahead_reg   <= ahead_q_reg;
                        chosen_display_reg <= display_q_reg;
                        pick_reg           <= scan_i_reg + 1'b1;
                    end
                    scan_i_reg <= scan_i_reg + 1'b1;
                    state_reg  <= ST_SCAN_RD;
                end

                ST_FIN: begin
                    chosen_cnt_reg <= ppc_pkg::PULSE_W'(pick_reg);
                    calib_reg      <= 1'b1;
                    res_pc_reg     <= ppc_pkg::PULSE_W'(pick_reg);
                    state_reg      <= ST_OUT;
                end

                // load the result register once it is free
                ST_OUT: begin
                    if (out_free) begin
                        m_valid_reg     <= 1'b1;
                        m_pc_reg        <= res_pc_reg;
                        m_ignored_reg   <= res_ignored_reg;
                        m_avg_valid_reg <= res_avg_valid_reg;
                        m_avg_reg       <= res_avg_reg;
                        m_done_reg      <= res_done_reg;
                        m_side_reg      <= res_side_reg;
                        m_calib_reg     <= calib_reg;
                        m_best_reg      <= chosen_cnt_reg;
                        m_ahead_reg     <= chosen_ahead_reg;
                        m_display_reg   <= chosen_display_reg;
                        state_reg       <= ST_IDLE;
                    end
                end

                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_pulse_count       = m_pc_reg;
    assign m_ignored           = m_ignored_reg;
    assign m_average_valid     = m_avg_valid_reg;
    assign m_average_level     = m_avg_reg;
    assign m_sweep_done        = m_done_reg;
    assign m_done_side         = m_side_reg;
    assign m_calibrated        = m_calib_reg;
    assign m_best_pulse_count  = m_best_reg;
    assign m_ahead_level_out   = m_ahead_reg;
    assign m_display_level_out = m_display_reg;

endmodule

// ===== sv/ppc_checker.sv =====
// Port-level checks for the proximity pulse calibration block, bound to the top.
`timescale 1ns / 1ps

module ppc_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_valid,
    input logic                             s_ready,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic [ppc_pkg::PULSE_W-1:0]      m_pulse_count,
    input logic                             m_ignored,
    input logic                             m_average_valid,
    input logic [ppc_pkg::LEVEL_W-1:0]      m_average_level,
    input logic                             m_sweep_done,
    input logic                             m_done_side,
    input logic                             m_calibrated,
    input logic [ppc_pkg::PULSE_W-1:0]      m_best_pulse_count
);

    // a stalled result beat holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pulse_count)
            && $stable(m_average_level))
        else $error("result beat changed while stalled");

    // one beat in work at a time: busy right after acceptance
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready right after an accepted beat");

    // an ignored reading neither averages nor ends a sweep
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ignored |-> !m_average_valid && !m_sweep_done
            && m_average_level == '0)
        else $error("ignored beat carries sweep results");

    // side and end flag agree; a sweep only ends on a completed average
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_done_side || m_sweep_done) |-> m_sweep_done && m_average_valid)
        else $error("sweep end without average");

    // no best count before calibration
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_calibrated |-> m_best_pulse_count == '0)
        else $error("best count reported before calibration");

endmodule

bind proximity_pulse_calibration ppc_checker u_ppc_checker (.*);

// ===== bench/proximity_pulse_calibration_tb.sv =====
// Self-checking bench for the proximity pulse-count sweep and best-count search.
`timescale 1ns / 1ps

module proximity_pulse_calibration_tb;

    // Slowest correct run: about 1350 beats, each at most an average plus a full
    // best-count search, plus sender gaps and receiver stalls; taken several times.
    localparam int CYCLE_LIMIT = 1_000_000;

    // One result beat as seen on the m_ side
    typedef struct packed {
        logic [ppc_pkg::PULSE_W-1:0] pulse_count;
        logic                        ignored;
        logic                        average_valid;
        logic [ppc_pkg::LEVEL_W-1:0] average_level;
        logic                        sweep_done;
        logic                        done_side;
        logic                        calibrated;
        logic [ppc_pkg::PULSE_W-1:0] best_pulse_count;
        logic [ppc_pkg::LEVEL_W-1:0] ahead_level;
        logic [ppc_pkg::LEVEL_W-1:0] display_level;
    } calib_report_t;

    // Tracks sweep state, predicts each result beat and checks it in order
    class calib_scoreboard;
        logic [ppc_pkg::SAMPLE_W-1:0] full_scale;
        logic [ppc_pkg::PULSE_W-1:0]  max_pulse;

        logic [ppc_pkg::LEVEL_W-1:0]  ahead_levels[ppc_pkg::STORE_DEPTH];
        logic [ppc_pkg::LEVEL_W-1:0]  display_levels[ppc_pkg::STORE_DEPTH];
        int unsigned                  ahead_entries;
        int unsigned                  display_entries;
        bit                           sweeping;
        bit                           sweeping_ahead;
        int unsigned                  slots;
        logic [ppc_pkg::SAMPLE_W-1:0] slot_sum;
        int unsigned                  next_entry;
        logic [ppc_pkg::STEP_W-1:0]   step_count;
        logic [ppc_pkg::PULSE_W-1:0]  best_count;
        logic [ppc_pkg::LEVEL_W-1:0]  best_ahead;
        logic [ppc_pkg::LEVEL_W-1:0]  best_display;
        bit                           have_best;

        calib_report_t expected_reports[$];
        int unsigned mismatches;
        int unsigned reports_checked;
        int unsigned sweeps_finished;
        int unsigned choices_made;

        function new();
            full_scale      = ppc_pkg::FULL_SCALE_RESET;
            max_pulse       = ppc_pkg::MAX_PULSE_RESET;
            ahead_entries   = 0;
            display_entries = 0;
            sweeping        = 1'b0;
            sweeping_ahead  = 1'b0;
            slots           = 0;
            slot_sum        = '0;
            next_entry      = 0;
            step_count      = ppc_pkg::STEP_W'(1);
            best_count      = '0;
            best_ahead      = '0;
            best_display    = '0;
            have_best       = 1'b0;
            mismatches      = 0;
            reports_checked = 0;
            sweeps_finished = 0;
            choices_made    = 0;
        endfunction

        // Predict the result of one accepted input beat
        function void note_beat(logic [1:0] act, logic [ppc_pkg::SAMPLE_W-1:0] rd);
            calib_report_t               r;
            logic [ppc_pkg::LEVEL_W-1:0] avg;
            logic [ppc_pkg::LEVEL_W-1:0] a_lvl;
            logic [ppc_pkg::LEVEL_W-1:0] d_lvl;
            logic [ppc_pkg::LEVEL_W-1:0] diff;
            logic [ppc_pkg::LEVEL_W-1:0] top_diff;
            int unsigned                 idx;
            int unsigned                 span;
            int unsigned                 pick;
            r = '0;
            if (act == ppc_pkg::ACT_BEGIN_AHEAD || act == ppc_pkg::ACT_BEGIN_DISPLAY) begin
                // a begin also abandons any running sweep
                sweeping       = 1'b1;
                sweeping_ahead = (act == ppc_pkg::ACT_BEGIN_AHEAD);
                slots          = 0;
                slot_sum       = '0;
                next_entry     = 0;
                step_count     = ppc_pkg::STEP_W'(1);
                r.pulse_count  = ppc_pkg::PULSE_W'(1);
            end else if (!sweeping) begin
                r.ignored     = 1'b1;
                r.pulse_count = have_best ? best_count : ppc_pkg::PULSE_W'(1);
            end else begin
                if (act == ppc_pkg::ACT_READING)
                    slot_sum = slot_sum + rd;
                slots++;
                r.pulse_count = step_count[ppc_pkg::PULSE_W-1:0];
                if (slots >= 3) begin
                    idx = (next_entry < ppc_pkg::STORE_DEPTH) ? next_entry
                                                              : ppc_pkg::STORE_DEPTH - 1;
                    avg = ppc_pkg::LEVEL_W'(slot_sum / 3);
                    if (sweeping_ahead)
                        ahead_levels[idx] = avg;
                    else
                        display_levels[idx] = avg;
                    r.average_valid = 1'b1;
                    r.average_level = avg;
                    slots      = 0;
                    slot_sum   = '0;
                    next_entry = idx + 1;
                    step_count = step_count + 1'b1;
                    r.pulse_count = step_count[ppc_pkg::PULSE_W-1:0];
                    if (avg >= full_scale || step_count > max_pulse ||
                            next_entry >= ppc_pkg::STORE_DEPTH) begin
                        r.sweep_done = 1'b1;
                        r.done_side  = sweeping_ahead;
                        sweeping     = 1'b0;
                        sweeps_finished++;
                        if (sweeping_ahead)
                            ahead_entries = next_entry;
                        else
                            display_entries = next_entry;
                        r.pulse_count = ppc_pkg::PULSE_W'(1);
                        if (ahead_entries != 0 && display_entries != 0) begin
                            // first entry with the largest absolute difference wins
                            span = (ahead_entries < display_entries) ? ahead_entries
                                                                     : display_entries;
                            top_diff = '0;
                            pick     = 1;
                            for (int i = 0; i < span; i++) begin
                                a_lvl = ahead_levels[i];
                                d_lvl = display_levels[i];
                                diff  = (a_lvl > d_lvl) ? a_lvl - d_lvl : d_lvl - a_lvl;
                                if (diff > top_diff) begin
                                    top_diff     = diff;
                                    best_ahead   = a_lvl;
                                    best_display = d_lvl;
                                    pick         = i + 1;
                                end
                            end
                            best_count    = ppc_pkg::PULSE_W'(pick);
                            have_best     = 1'b1;
                            r.pulse_count = best_count;
                            choices_made++;
                        end
                    end
                end
            end
            r.calibrated       = have_best;
            r.best_pulse_count = best_count;
            r.ahead_level      = best_ahead;
            r.display_level    = best_display;
            expected_reports.push_back(r);
        endfunction

        function string show(calib_report_t r);
            return $sformatf({"pc=%0d ign=%0b avg_v=%0b avg=%0d done=%0b side=%0b ",
                              "cal=%0b best=%0d ahead=%0d disp=%0d"},
                             r.pulse_count, r.ignored, r.average_valid, r.average_level,
                             r.sweep_done, r.done_side, r.calibrated, r.best_pulse_count,
                             r.ahead_level, r.display_level);
        endfunction

        // Compare one accepted result beat with the oldest prediction
        function void check_report(calib_report_t got);
            calib_report_t want;
            if (expected_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] unexpected result beat: %s", $time, show(got));
                return;
            end
            want = expected_reports.pop_front();
            reports_checked++;
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("[%0t] mismatch on result %0d", $time, reports_checked);
                    $display("    expected %s", show(want));
                    $display("    actual   %s", show(got));
                end
            end
        endfunction
    endclass

    logic                           aclk;
    logic                           aresetn   = 1'b0;
    logic                           cfg_wr_en = 1'b0;
    logic [ppc_pkg::CFG_IDX_W-1:0]  cfg_index = ppc_pkg::REG_FULL_SCALE;
    logic [ppc_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                           s_valid   = 1'b0;
    logic                           s_ready;
    logic [1:0]                     s_action  = ppc_pkg::ACT_MISSED;
    logic [ppc_pkg::SAMPLE_W-1:0]   s_reading = '0;
    logic                           m_valid;
    logic                           m_ready   = 1'b0;
    logic [ppc_pkg::PULSE_W-1:0]    m_pulse_count;
    logic                           m_ignored;
    logic                           m_average_valid;
    logic [ppc_pkg::LEVEL_W-1:0]    m_average_level;
    logic                           m_sweep_done;
    logic                           m_done_side;
    logic                           m_calibrated;
    logic [ppc_pkg::PULSE_W-1:0]    m_best_pulse_count;
    logic [ppc_pkg::LEVEL_W-1:0]    m_ahead_level_out;
    logic [ppc_pkg::LEVEL_W-1:0]    m_display_level_out;

    calib_scoreboard sb;
    int unsigned     send_idle_pct = 27;
    int unsigned     recv_idle_pct = 56;
    int unsigned     cycles        = 0;
    int unsigned     beats_sent    = 0;
    int unsigned     settings_used = 0;

    proximity_pulse_calibration uut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_index           (cfg_index),
        .cfg_wdata           (cfg_wdata),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_action            (s_action),
        .s_reading           (s_reading),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_pulse_count       (m_pulse_count),
        .m_ignored           (m_ignored),
        .m_average_valid     (m_average_valid),
        .m_average_level     (m_average_level),
        .m_sweep_done        (m_sweep_done),
        .m_done_side         (m_done_side),
        .m_calibrated        (m_calibrated),
        .m_best_pulse_count  (m_best_pulse_count),
        .m_ahead_level_out   (m_ahead_level_out),
        .m_display_level_out (m_display_level_out)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    // Receiver backpressure
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Result monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_report('{m_pulse_count, m_ignored, m_average_valid, m_average_level,
                              m_sweep_done, m_done_side, m_calibrated, m_best_pulse_count,
                              m_ahead_level_out, m_display_level_out});
    end

    // Mostly sensor-like levels, some mid-range, some full 16-bit
    function automatic logic [ppc_pkg::SAMPLE_W-1:0] draw_reading();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 55)
            return ppc_pkg::SAMPLE_W'($urandom_range(0, 1500));
        else if (sel < 85)
            return ppc_pkg::SAMPLE_W'($urandom_range(0, 12000));
        return ppc_pkg::SAMPLE_W'($urandom_range(0, 65535));
    endfunction

    // Drive one input beat, with random leading idle cycles
    task automatic send_beat(input logic [1:0] act,
                             input logic [ppc_pkg::SAMPLE_W-1:0] rd);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_action  <= act;
        s_reading <= rd;
        do @(posedge aclk); while (!s_ready);
        sb.note_beat(act, rd);
        beats_sent++;
    endtask

    // Sender holds off until every predicted result has been taken
    task automatic hold_until_drained();
        s_valid <= 1'b0;
        while (sb.expected_reports.size() != 0)
            @(posedge aclk);
    endtask

    // Write both registers while the block is idle
    task automatic configure(input logic [ppc_pkg::SAMPLE_W-1:0] fs,
                             input logic [ppc_pkg::PULSE_W-1:0] mp);
        hold_until_drained();
        repeat (8) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= ppc_pkg::REG_FULL_SCALE;
        cfg_wdata <= fs;
        @(posedge aclk);
        cfg_index <= ppc_pkg::REG_MAX_PULSE;
        cfg_wdata <= ppc_pkg::CFG_DATA_W'(mp);
        @(posedge aclk);
        cfg_wr_en     <= 1'b0;
        sb.full_scale = fs;
        sb.max_pulse  = mp;
        settings_used++;
    endtask

    // Random sweeps: mostly complete begin-then-readings sequences, some
    // abandoned by a fresh begin, some stray readings while idle
    task automatic run_phase(input logic [ppc_pkg::SAMPLE_W-1:0] fs,
                             input logic [ppc_pkg::PULSE_W-1:0] mp,
                             input int unsigned send_pct, input int unsigned recv_pct,
                             input int unsigned quota);
        int unsigned                  counted;
        int unsigned                  since_begin;
        int unsigned                  abandon_at;
        logic [1:0]                   act;
        logic [ppc_pkg::SAMPLE_W-1:0] rd;
        bit                           stray;
        configure(fs, mp);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        counted       = 0;
        since_begin   = 0;
        abandon_at    = 0;
        while (counted < quota) begin
            stray = 1'b0;
            if (!sb.sweeping && $urandom_range(0, 99) < 15) begin
                act   = $urandom_range(0, 1) ? ppc_pkg::ACT_READING : ppc_pkg::ACT_MISSED;
                rd    = draw_reading();
                stray = 1'b1;
            end else if (!sb.sweeping || (abandon_at != 0 && since_begin == abandon_at)) begin
                act         = $urandom_range(0, 1) ? ppc_pkg::ACT_BEGIN_AHEAD
                                                   : ppc_pkg::ACT_BEGIN_DISPLAY;
                rd          = ppc_pkg::SAMPLE_W'($urandom_range(0, 65535));
                since_begin = 0;
                abandon_at  = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 20) : 0;
            end else begin
                act = ($urandom_range(0, 9) == 0) ? ppc_pkg::ACT_MISSED : ppc_pkg::ACT_READING;
                rd  = draw_reading();
                since_begin++;
            end
            send_beat(act, rd);
            if (!stray)
                counted++;
            // occasional full stop of the sender mid-phase
            if ($urandom_range(0, 199) == 0)
                hold_until_drained();
        end
    endtask

    initial begin
        sb = new();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Readings with no sweep running are ignored
        send_beat(ppc_pkg::ACT_READING, 16'hFFFF);
        send_beat(ppc_pkg::ACT_MISSED, 16'h0000);

        // Zero pulse limit: sweep ends after one average, display side still empty
        configure(16'd1023, 8'd0);
        send_beat(ppc_pkg::ACT_BEGIN_AHEAD, 16'hFFFF);
        send_beat(ppc_pkg::ACT_READING, 16'd30);
        send_beat(ppc_pkg::ACT_MISSED, 16'hFFFF);
        send_beat(ppc_pkg::ACT_MISSED, 16'h0000);

        // Equal levels on both sides: no difference, count 1 is chosen
        send_beat(ppc_pkg::ACT_BEGIN_DISPLAY, 16'h0000);
        repeat (3) send_beat(ppc_pkg::ACT_READING, 16'd10);

        // Level limit out of reach, pulse limit 1
        configure(16'hFFFF, 8'd1);
        send_beat(ppc_pkg::ACT_BEGIN_AHEAD, 16'h0000);
        repeat (3) send_beat(ppc_pkg::ACT_READING, 16'd300);

        // Begin while a sweep runs, then a wrapping sum of full-scale readings
        send_beat(ppc_pkg::ACT_BEGIN_DISPLAY, 16'h0000);
        send_beat(ppc_pkg::ACT_READING, 16'd100);
        send_beat(ppc_pkg::ACT_BEGIN_AHEAD, 16'h0000);
        repeat (3) send_beat(ppc_pkg::ACT_READING, 16'hFFFF);

        // Idle reading once a count has been chosen
        send_beat(ppc_pkg::ACT_READING, 16'h5555);

        // Receiver idles more than the sender
        run_phase(16'd2000, 8'd6, 27, 56, 220);
        run_phase(16'd0, 8'd255, 27, 56, 130);
        // Sender idles more than the receiver; first phase fills the store
        run_phase(16'hFFFF, 8'd255, 56, 27, 400);
        run_phase(ppc_pkg::SAMPLE_W'($urandom_range(200, 20000)),
                  ppc_pkg::PULSE_W'($urandom_range(1, 12)), 56, 27, 200);
        // No idling on either side
        run_phase(16'd1023, 8'd1, 0, 0, 150);
        run_phase(ppc_pkg::SAMPLE_W'($urandom_range(0, 65535)),
                  ppc_pkg::PULSE_W'($urandom_range(0, 255)), 0, 0, 200);

        // Drain, then allow for a full best-count search before closing
        hold_until_drained();
        repeat (2 * ppc_pkg::STORE_DEPTH + 20) @(posedge aclk);

        $display("Drove %0d beats over %0d register settings; %0d results checked.",
                 beats_sent, settings_used, sb.reports_checked);
        $display("Sweeps finished: %0d, best-count choices: %0d, mismatches: %0d.",
                 sb.sweeps_finished, sb.choices_made, sb.mismatches);
        if (sb.mismatches == 0 && sb.expected_reports.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
